// ===== rtl/rqts_pkg.sv =====
// Shared types and constants of the ready-queue thread scheduler.
package rqts_pkg;

    localparam int ID_W            = 6;
    localparam int DEF_MAX_THREADS = 64;

    typedef enum logic [2:0] {
        Q_NONE,
        Q_SEARCH,
        Q_APPEND,
        Q_PUSH,
        Q_POP,
        Q_REMOVE
    } q_op_t;

    typedef struct packed {
        q_op_t           op;
        logic [ID_W-1:0] key;
    } q_cmd_t;

    typedef struct packed {
        logic            found;
        logic            nonempty;
        logic [ID_W-1:0] head;
    } q_stat_t;

    typedef struct packed {
        logic append;
        logic push;
        logic shift_left;
    } cell_ctl_t;

endpackage

// ===== rtl/rqts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module rqts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rqts_cell.sv =====
// One slot of the ready deque: holds a thread id and takes it from a neighbour on a shift.
module rqts_cell
    import rqts_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
)(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [ID_W-1:0]  key,
    input  logic [CNT_W-1:0] count,
    input  logic [CNT_W-1:0] shift_from,
    input  logic [ID_W-1:0]  left_id,
    input  logic [ID_W-1:0]  right_id,
    output logic [ID_W-1:0]  id,
    output logic             match
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;

    always_comb
    begin
        id_next = id_reg;
        if (ctl.append && (count == MY_POS))
        begin
            id_next = key;
        end
        else if (ctl.push)
        begin
            // The head cell sees the key on its left input.
            id_next = left_id;
        end
        else if (ctl.shift_left && (MY_POS >= shift_from))
        begin
            id_next = right_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id    = id_reg;
    assign match = (MY_POS < count) && (id_reg == key);

endmodule

// ===== rtl/rqts_queue.sv =====
// Ready deque built as a row of cells, with fill count and registered search result.
module rqts_queue
    import rqts_pkg::*;
#(
    parameter int MAX_THREADS = DEF_MAX_THREADS
)(
    input  logic    clk,
    input  logic    rst_n,
    input  q_cmd_t  cmd,
    output q_stat_t stat
);

    localparam int CNT_W = $clog2(MAX_THREADS + 1);
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_THREADS);

    logic [ID_W-1:0]        cell_id [MAX_THREADS];
    logic [MAX_THREADS-1:0] match;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   found_reg, found_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       match_pos;
    logic [CNT_W-1:0]       shift_from;
    logic                   may_add;
    cell_ctl_t              ctl;

    // Ids in the deque are distinct, so at most one cell matches.
    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            if (match[i])
            begin
                match_pos = match_pos | CNT_W'(i);
            end
        end
    end

    assign may_add = !found_reg && (count_reg < CAPACITY);

    always_comb
    begin
        ctl        = '0;
        shift_from = '0;
        count_next = count_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        case (cmd.op)
            Q_SEARCH:
            begin
                found_next = |match;
                pos_next   = match_pos;
            end
            Q_APPEND:
            begin
                ctl.append = may_add;
                if (may_add)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            Q_PUSH:
            begin
                ctl.push = may_add;
                if (may_add)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            Q_POP:
            begin
                ctl.shift_left = (count_reg != '0);
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            Q_REMOVE:
            begin
                ctl.shift_left = found_reg;
                shift_from     = pos_reg;
                if (found_reg)
                begin
                    count_next = count_reg - 1'b1;
                    found_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar i = 0; i < MAX_THREADS; i++)
    begin : g_cell
        logic [ID_W-1:0] left_w;
        logic [ID_W-1:0] right_w;

        if (i == 0)
        begin : g_head
            assign left_w = cmd.key;
        end
        else
        begin : g_body
            assign left_w = cell_id[i-1];
        end

        if (i == MAX_THREADS - 1)
        begin : g_tail
            assign right_w = '0;
        end
        else
        begin : g_inner
            assign right_w = cell_id[i+1];
        end

        rqts_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .key        (cmd.key),
            .count      (count_reg),
            .shift_from (shift_from),
            .left_id    (left_w),
            .right_id   (right_w),
            .id         (cell_id[i]),
            .match      (match[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            found_reg <= found_next;
            pos_reg   <= pos_next;
        end
    end

    assign stat.found    = found_reg;
    assign stat.nonempty = (count_reg != '0);
    assign stat.head     = cell_id[0];

endmodule

// ===== rtl/ready_queue_thread_scheduler.sv =====
// Top level of the ready-queue thread scheduler: event sequencer, status table and deque.
//
// Each input transaction is one scheduler event and yields exactly one output transaction
// with the running thread, a switched flag and an error code. Events are handled one at a
// time by a sequencer, which steps around the per-thread status RAM, whose read is
// registered, and around the deque search, which is registered before an append or a
// removal. A new result waits in the sequencer until the previous one has left the output
// register. The deque is a row of cells that all shift together. Status entries read as
// their reset value until first written, so no clearing pass is needed. The next event is
// taken as soon as the result has been placed in the output register.
module ready_queue_thread_scheduler
    import rqts_pkg::*;
#(
    parameter int MAX_THREADS = DEF_MAX_THREADS
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [5:0] thread_id, [7:6] block_kind, [8] resched flag
    input  logic [2:0]  s_axis_tuser,  // [2:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [5:0] running_id, [6] switched, [8:7] error
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata
);

    localparam int ID_SPACE     = 2 ** ID_W;
    localparam int THREAD_SLOTS = (MAX_THREADS < ID_SPACE) ? MAX_THREADS : ID_SPACE;
    localparam int SLOT_W       = $clog2(THREAD_SLOTS);
    localparam int ST_W         = 3;
    localparam logic [ID_W:0] ID_LIMIT = (ID_W + 1)'(THREAD_SLOTS);
    localparam logic [ID_W-1:0] IDLE_RESET = ID_W'(1);

    typedef enum logic [2:0] {
        ST_RUNNING = 3'd0,
        ST_READY   = 3'd1,
        ST_BLOCKED = 3'd2,
        ST_WAITING = 3'd3,
        ST_HANGING = 3'd4,
        ST_DIED    = 3'd5
    } thread_status_t;

    typedef enum logic [2:0] {
        OP_SLICE_END = 3'd0,
        OP_BLOCK     = 3'd1,
        OP_UNBLOCK   = 3'd2,
        OP_YIELD     = 3'd3,
        OP_EXIT      = 3'd4,
        OP_CREATE    = 3'd5
    } event_op_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_QUEUED      = 2'd1,
        ERR_NOT_BLOCKED = 2'd2
    } err_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RS_READ,
        S_RS_CHECK,
        S_CUR_APPEND,
        S_POP,
        S_EXIT_REMOVE,
        S_CREATE_APPEND,
        S_UNB_CHECK,
        S_DONE
    } state_t;

    function automatic thread_status_t block_status(input logic [1:0] kind);
        thread_status_t st;
        case (kind)
            2'd1:    st = ST_WAITING;
            2'd2:    st = ST_HANGING;
            default: st = ST_BLOCKED;
        endcase
        return st;
    endfunction

    state_t            state_reg, state_next;
    logic [ID_W-1:0]   cur_reg, cur_next;
    logic [ID_W-1:0]   idle_reg, idle_next;
    logic [ID_W-1:0]   tid_reg, tid_next;
    logic              need_reg, need_next;
    logic              force_reg, force_next;
    logic              sw_reg, sw_next;
    err_t              err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_run_reg, out_run_next;
    logic              out_sw_reg, out_sw_next;
    err_t              out_err_reg, out_err_next;
    logic [THREAD_SLOTS-1:0] st_valid_reg;
    logic              rd_valid_reg;
    logic              rd_zero_reg;

    logic [ID_W-1:0]   in_tid;
    logic [1:0]        in_kind;
    logic              in_need;
    logic              tid_ok;
    logic              idle_ok;
    q_cmd_t            q_cmd;
    q_stat_t           q_stat;
    logic              st_we;
    logic [SLOT_W-1:0] st_waddr;
    thread_status_t    st_wdata;
    logic [SLOT_W-1:0] st_raddr;
    logic [ST_W-1:0]   st_rdata;
    thread_status_t    rd_status;
    logic              pick;
    logic [ID_W-1:0]   pick_id;

    assign in_tid  = s_axis_tdata[ID_W-1:0];
    assign in_kind = s_axis_tdata[ID_W+1:ID_W];
    assign in_need = s_axis_tdata[ID_W+2];
    assign tid_ok  = ({1'b0, in_tid} < ID_LIMIT);
    assign idle_ok = ({1'b0, idle_reg} < ID_LIMIT);

    // An entry never written still reads as its reset value.
    assign rd_status = rd_valid_reg ? thread_status_t'(st_rdata)
                                    : (rd_zero_reg ? ST_RUNNING : ST_DIED);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idle_next      = cfg_we ? cfg_wdata : idle_reg;
        tid_next       = tid_reg;
        need_next      = need_reg;
        force_next     = force_reg;
        sw_next        = sw_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_run_next   = out_run_reg;
        out_sw_next    = out_sw_reg;
        out_err_next   = out_err_reg;
        q_cmd.op       = Q_NONE;
        q_cmd.key      = cur_reg;
        st_we          = 1'b0;
        st_waddr       = cur_reg[SLOT_W-1:0];
        st_wdata       = ST_READY;
        st_raddr       = cur_reg[SLOT_W-1:0];
        pick           = 1'b0;
        pick_id        = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                st_raddr = in_tid[SLOT_W-1:0];
                if (s_axis_tvalid)
                begin
                    tid_next   = in_tid;
                    need_next  = in_need;
                    force_next = 1'b0;
                    sw_next    = 1'b0;
                    err_next   = ERR_NONE;
                    state_next = S_DONE;
                    unique case (s_axis_tuser)
                        OP_SLICE_END:
                        begin
                            state_next = S_RS_READ;
                        end
                        OP_BLOCK:
                        begin
                            st_we      = 1'b1;
                            st_wdata   = block_status(in_kind);
                            state_next = S_POP;
                        end
                        OP_YIELD:
                        begin
                            force_next = 1'b1;
                            state_next = S_RS_READ;
                        end
                        OP_UNBLOCK:
                        begin
                            if (tid_ok)
                            begin
                                q_cmd.op   = Q_SEARCH;
                                q_cmd.key  = in_tid;
                                state_next = S_UNB_CHECK;
                            end
                        end
                        OP_EXIT:
                        begin
                            if (tid_ok)
                            begin
                                st_we      = 1'b1;
                                st_waddr   = in_tid[SLOT_W-1:0];
                                st_wdata   = ST_DIED;
                                q_cmd.op   = Q_SEARCH;
                                q_cmd.key  = in_tid;
                                state_next = S_EXIT_REMOVE;
                            end
                        end
                        OP_CREATE:
                        begin
                            if (tid_ok)
                            begin
                                st_we      = 1'b1;
                                st_waddr   = in_tid[SLOT_W-1:0];
                                st_wdata   = ST_READY;
                                q_cmd.op   = Q_SEARCH;
                                q_cmd.key  = in_tid;
                                state_next = S_CREATE_APPEND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RS_READ:
            begin
                q_cmd.op   = Q_SEARCH;
                state_next = S_RS_CHECK;
            end
            S_RS_CHECK:
            begin
                // A yield requeues the current thread whatever its status.
                if ((rd_status == ST_RUNNING) || force_reg)
                begin
                    state_next = S_CUR_APPEND;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_CUR_APPEND:
            begin
                q_cmd.op   = Q_APPEND;
                st_we      = 1'b1;
                st_wdata   = ST_READY;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (q_stat.nonempty)
                begin
                    q_cmd.op = Q_POP;
                    pick     = 1'b1;
                    pick_id  = q_stat.head;
                end
                else if (idle_ok)
                begin
                    pick    = 1'b1;
                    pick_id = idle_reg;
                end
                if (pick)
                begin
                    st_we    = 1'b1;
                    st_waddr = pick_id[SLOT_W-1:0];
                    st_wdata = ST_RUNNING;
                    cur_next = pick_id;
                    sw_next  = 1'b1;
                end
                state_next = S_DONE;
            end
            S_EXIT_REMOVE:
            begin
                q_cmd.op   = Q_REMOVE;
                state_next = need_reg ? S_RS_READ : S_DONE;
            end
            S_CREATE_APPEND:
            begin
                q_cmd.op   = Q_APPEND;
                q_cmd.key  = tid_reg;
                state_next = S_DONE;
            end
            S_UNB_CHECK:
            begin
                if ((rd_status != ST_BLOCKED) && (rd_status != ST_WAITING) &&
                    (rd_status != ST_HANGING))
                begin
                    err_next = ERR_NOT_BLOCKED;
                end
                else if (q_stat.found)
                begin
                    err_next = ERR_QUEUED;
                end
                else
                begin
                    st_we     = 1'b1;
                    st_waddr  = tid_reg[SLOT_W-1:0];
                    st_wdata  = ST_READY;
                    q_cmd.op  = Q_PUSH;
                    q_cmd.key = tid_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_run_next   = cur_reg;
                    out_sw_next    = sw_reg;
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            idle_reg      <= IDLE_RESET;
            tid_reg       <= '0;
            need_reg      <= 1'b0;
            force_reg     <= 1'b0;
            sw_reg        <= 1'b0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
            out_run_reg   <= '0;
            out_sw_reg    <= 1'b0;
            out_err_reg   <= ERR_NONE;
            st_valid_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            rd_zero_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            idle_reg      <= idle_next;
            tid_reg       <= tid_next;
            need_reg      <= need_next;
            force_reg     <= force_next;
            sw_reg        <= sw_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            out_run_reg   <= out_run_next;
            out_sw_reg    <= out_sw_next;
            out_err_reg   <= out_err_next;
            if (st_we)
            begin
                st_valid_reg[st_waddr] <= 1'b1;
            end
            rd_valid_reg  <= st_valid_reg[st_raddr];
            rd_zero_reg   <= (st_raddr == '0);
        end
    end

    rqts_ram #(
        .WIDTH (ST_W),
        .DEPTH (THREAD_SLOTS)
    ) u_status_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    rqts_queue #(
        .MAX_THREADS (MAX_THREADS)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (q_cmd),
        .stat  (q_stat)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_err_reg, out_sw_reg, out_run_reg};

    // Only one event is in flight, so a transaction is never followed straight by another.
    a_one_event_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("scheduler accepted two events back to back");

    // A pick from a non-empty deque makes its head the running thread.
    a_pop_takes_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) && q_stat.nonempty |=> (cur_reg == $past(q_stat.head)))
        else $error("reschedule did not run the head of the ready deque");

    // Unblock never reschedules, so an error and a switch never come together.
    a_no_error_on_switch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(out_sw_reg && (out_err_reg != ERR_NONE)))
        else $error("result carries both a switch and an error");

endmodule
